[hdl/sync_length_xor_frame_parser_defines.svh]
// Assertion macros for the frame parser checker.
`ifndef SYNC_LENGTH_XOR_FRAME_PARSER_DEFINES_SVH
`define SYNC_LENGTH_XOR_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SLXFP_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SLXFP_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/slxfp_pkg.sv]
// Shared constants and types of the sync/length/XOR frame parser.
`default_nettype none

package slxfp_pkg;

  localparam int MAX_PAYLOAD_DEF = 16;
  localparam int IDX_MAX_W       = 6;
  localparam int LEN_MAX_W       = 7;
  localparam int CMDQ_DEPTH      = 2;
  localparam int CFG_IDX_W       = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SYNC_VALUE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FUNCTION_CODE = 2'd1;

  localparam logic [7:0] SYNC_RESET = 8'hFF;
  localparam logic [7:0] FUNC_RESET = 8'h10;

  localparam logic [1:0] ST_GOOD     = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_BADSUM   = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  typedef struct packed {
    logic [1:0]           status;
    logic [LEN_MAX_W-1:0] len;
  } frame_cmd_t;

  typedef struct packed {
    logic                 we;
    logic [IDX_MAX_W-1:0] addr;
    logic [7:0]           data;
  } store_wr_t;

  typedef struct packed {
    logic full;
    logic empty;
  } cmdq_status_t;

endpackage

`default_nettype wire

[hdl/slxfp_if.sv]
// Valid/ready channel interfaces for the received byte and result streams.
`default_nettype none

interface slxfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slxfp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic [5:0] byte_index;
  logic       last;
  logic [1:0] status;

  modport source (output valid, output payload_byte, output byte_index, output last,
                  output status, input ready);
  modport sink   (input valid, input payload_byte, input byte_index, input last,
                  input status, output ready);
endinterface

`default_nettype wire

[hdl/slxfp_front.sv]
// Front end: byte intake, frame phase tracking, payload store writes, frame commands.
`default_nettype none

module slxfp_front
  import slxfp_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_wdata,
  slxfp_in_if.sink             in_ch,
  input  cmdq_status_t         q_stat,
  input  logic                 back_busy,
  output logic                 push,
  output frame_cmd_t           push_cmd,
  output store_wr_t            st_wr
);

  localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

  localparam logic [2:0] PH_HUNT  = 3'd0;
  localparam logic [2:0] PH_FUNC  = 3'd1;
  localparam logic [2:0] PH_LEN   = 3'd2;
  localparam logic [2:0] PH_DATA  = 3'd3;
  localparam logic [2:0] PH_CHECK = 3'd4;

  logic [2:0]       phase_r, phase_nxt;
  logic [7:0]       sync_r, sync_nxt;
  logic [7:0]       func_r, func_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] taken_r, taken_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic             accept;
  logic [7:0]       b;

  assign b      = in_ch.rx_byte;
  assign accept = in_ch.valid && in_ch.ready;

  // Payload waits for idle back end and empty queue; length/checksum for queue room.
  always_comb begin
    unique case (phase_r)
      PH_LEN, PH_CHECK: in_ch.ready = !q_stat.full;
      PH_DATA:          in_ch.ready = !back_busy && q_stat.empty;
      default:          in_ch.ready = 1'b1;
    endcase
  end

  always_comb begin
    phase_nxt     = phase_r;
    sync_nxt      = sync_r;
    func_nxt      = func_r;
    len_nxt       = len_r;
    taken_nxt     = taken_r;
    xor_nxt       = xor_r;
    push          = 1'b0;
    push_cmd      = '0;
    st_wr.we      = 1'b0;
    st_wr.addr    = IDX_MAX_W'(taken_r);
    st_wr.data    = b;

    if (accept) begin
      unique case (phase_r)
        PH_FUNC: begin
          phase_nxt = (b == func_r) ? PH_LEN : PH_HUNT;
        end
        PH_LEN: begin
          if (b > 8'(MAX_PAYLOAD)) begin
            push            = 1'b1;
            push_cmd.status = ST_OVERFLOW;
            phase_nxt       = PH_HUNT;
          end else begin
            len_nxt   = LEN_W'(b);
            taken_nxt = '0;
            xor_nxt   = '0;
            phase_nxt = (b == 8'd0) ? PH_CHECK : PH_DATA;
          end
        end
        PH_DATA: begin
          st_wr.we  = 1'b1;
          xor_nxt   = xor_r ^ b;
          taken_nxt = taken_r + LEN_W'(1);
          if (taken_nxt == len_r) begin
            phase_nxt = PH_CHECK;
          end
        end
        PH_CHECK: begin
          push         = 1'b1;
          push_cmd.len = LEN_MAX_W'(len_r);
          if (b != xor_r) begin
            push_cmd.status = ST_BADSUM;
          end else if (len_r == '0) begin
            push_cmd.status = ST_EMPTY;
          end else begin
            push_cmd.status = ST_GOOD;
          end
          phase_nxt = PH_HUNT;
        end
        default: begin
          phase_nxt = (b == sync_r) ? PH_FUNC : PH_HUNT;
        end
      endcase
    end

    if (cfg_we) begin
      unique case (cfg_index)
        REG_SYNC_VALUE:    sync_nxt = cfg_wdata;
        REG_FUNCTION_CODE: func_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      sync_r  <= SYNC_RESET;
      func_r  <= FUNC_RESET;
      len_r   <= '0;
      taken_r <= '0;
      xor_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      sync_r  <= sync_nxt;
      func_r  <= func_nxt;
      len_r   <= len_nxt;
      taken_r <= taken_nxt;
      xor_r   <= xor_nxt;
    end
  end

endmodule

`default_nettype wire

[hdl/slxfp_cmdq.sv]
// Short command queue between the front end and the result sequencer.
`default_nettype none

module slxfp_cmdq
  import slxfp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  frame_cmd_t   push_cmd,
  input  logic         pop,
  output frame_cmd_t   head,
  output cmdq_status_t stat
);

  localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

  frame_cmd_t       q_r [CMDQ_DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign head       = q_r[rptr_r];
  assign stat.full  = (cnt_r == CNT_W'(CMDQ_DEPTH));
  assign stat.empty = (cnt_r == '0);

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wptr_r + PTR_W'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rptr_r + PTR_W'(1);
    end
    priority if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[hdl/slxfp_back.sv]
// Back end: payload store and result sequencer with registered output.
`default_nettype none

module slxfp_back
  import slxfp_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  store_wr_t    st_wr,
  input  frame_cmd_t   head,
  input  cmdq_status_t q_stat,
  output logic         pop,
  output logic         busy,
  slxfp_out_if.source  out_ch
);

  localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

  logic [7:0]           store_r [MAX_PAYLOAD];
  logic [7:0]           rd_data_r;
  logic                 rd_ok_r, rd_ok_nxt;
  logic                 busy_r, busy_nxt;
  logic [LEN_W-1:0]     len_r, len_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_payload_r, out_payload_nxt;
  logic [IDX_MAX_W-1:0] out_index_r, out_index_nxt;
  logic                 out_last_r, out_last_nxt;
  logic [1:0]           out_status_r, out_status_nxt;
  logic                 slot_free;
  logic                 load_good;
  logic                 final_byte;

  assign slot_free  = !out_valid_r || out_ch.ready;
  assign pop        = !busy_r && !q_stat.empty && slot_free;
  // rd_ok_r marks that rd_data_r holds the entry at idx_r
  assign load_good  = busy_r && rd_ok_r && slot_free;
  assign final_byte = (LEN_W'(idx_r) + LEN_W'(1) == len_r);
  assign busy       = busy_r;

  always_comb begin
    busy_nxt        = busy_r;
    len_nxt         = len_r;
    idx_nxt         = idx_r;
    rd_ok_nxt       = busy_r && !load_good;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_payload_nxt = out_payload_r;
    out_index_nxt   = out_index_r;
    out_last_nxt    = out_last_r;
    out_status_nxt  = out_status_r;

    if (pop) begin
      if (head.status == ST_GOOD) begin
        busy_nxt = 1'b1;
        len_nxt  = LEN_W'(head.len);
        idx_nxt  = '0;
      end else begin
        out_valid_nxt   = 1'b1;
        out_payload_nxt = '0;
        out_index_nxt   = '0;
        out_last_nxt    = 1'b1;
        out_status_nxt  = head.status;
      end
    end

    if (load_good) begin
      out_valid_nxt   = 1'b1;
      out_payload_nxt = rd_data_r;
      out_index_nxt   = IDX_MAX_W'(idx_r);
      out_last_nxt    = final_byte;
      out_status_nxt  = ST_GOOD;
      if (final_byte) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_wr.we) begin
      store_r[st_wr.addr[IDX_W-1:0]] <= st_wr.data;
    end
    rd_data_r <= store_r[idx_r];
  end

  always_ff @(posedge clk) begin
    out_payload_r <= out_payload_nxt;
    out_index_r   <= out_index_nxt;
    out_last_r    <= out_last_nxt;
    out_status_r  <= out_status_nxt;
    len_r         <= len_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      rd_ok_r     <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      rd_ok_r     <= rd_ok_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.payload_byte = out_payload_r;
  assign out_ch.byte_index   = out_index_r;
  assign out_ch.last         = out_last_r;
  assign out_ch.status       = out_status_r;

endmodule

`default_nettype wire

[hdl/sync_length_xor_frame_parser.sv]
// Error, overflow and empty-frame results pass the queue and then the output register;
//   good-frame bytes pass the queue, the index, store read and output registers in turn.
// Throughput: 1 byte/cycle; payload bytes wait for an empty command queue and an idle
//   back end, length and checksum bytes stall while the 2-deep command queue is full.
// Reset: synchronous, active low; clears phase, counters, queue and output valid, loads
//   sync_value 0xFF and function_code 0x10; payload store is not cleared.
`default_nettype none

module sync_length_xor_frame_parser
  import slxfp_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_wdata,
  slxfp_in_if.sink             in_ch,
  slxfp_out_if.source          out_ch
);

  cmdq_status_t q_stat;
  frame_cmd_t   push_cmd;
  frame_cmd_t   head;
  store_wr_t    st_wr;
  logic         push;
  logic         pop;
  logic         back_busy;

  slxfp_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .q_stat    (q_stat),
    .back_busy (back_busy),
    .push      (push),
    .push_cmd  (push_cmd),
    .st_wr     (st_wr)
  );

  slxfp_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  slxfp_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .st_wr  (st_wr),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .busy   (back_busy),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

[hdl/slxfp_checker.sv]
// Port-level checker for the frame parser result stream, bound to the top level.
`default_nettype none
`include "sync_length_xor_frame_parser_defines.svh"

module slxfp_checker
  import slxfp_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_payload_byte,
  input wire logic [5:0] out_byte_index,
  input wire logic       out_last,
  input wire logic [1:0] out_status
);

  `SLXFP_ASSERT_NEXT(a_out_valid_hold, clk, rst_n, out_valid && !out_ready, out_valid, "out valid dropped while stalled")

  `SLXFP_ASSERT_NEXT(a_out_word_hold, clk, rst_n, out_valid && !out_ready, $stable(out_payload_byte) && $stable(out_byte_index) && $stable(out_last) && $stable(out_status), "out word changed while stalled")

  // Error, overflow and empty results stand alone with zeroed data.
  `SLXFP_ASSERT_NOW(a_status_word_clean, clk, rst_n, out_valid && (out_status != ST_GOOD), out_last && (out_payload_byte == 8'd0) && (out_byte_index == 6'd0), "non-payload result not clean")

  `SLXFP_ASSERT_NOW(a_open_frame_is_good, clk, rst_n, out_valid && !out_last, out_status == ST_GOOD, "non-final result without good status")

endmodule

bind sync_length_xor_frame_parser slxfp_checker u_slxfp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_payload_byte (out_ch.payload_byte),
  .out_byte_index   (out_ch.byte_index),
  .out_last         (out_ch.last),
  .out_status       (out_ch.status)
);

`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for the sync/length/XOR frame parser.
`timescale 1ns / 1ps

import slxfp_pkg::*;

typedef enum logic [2:0] {
  PH_HUNT,
  PH_FUNC,
  PH_LEN,
  PH_DATA,
  PH_CHECK
} parse_phase_e;

typedef struct packed {
  logic [7:0] payload_byte;
  logic [5:0] byte_index;
  logic       last;
  logic [1:0] status;
} frame_word_t;

// Tracks the parser state byte by byte and holds the words it should emit.
class frame_checker;
  logic [7:0]   sync_value;
  logic [7:0]   function_code;
  parse_phase_e phase;
  logic [7:0]   frame_length;
  logic [6:0]   bytes_taken;
  logic [7:0]   running_xor;
  logic [7:0]   payload_store [MAX_PAYLOAD_DEF];
  frame_word_t  pending_words [$];
  int unsigned  errors;

  function new();
    sync_value    = SYNC_RESET;
    function_code = FUNC_RESET;
    phase         = PH_HUNT;
    frame_length  = '0;
    bytes_taken   = '0;
    running_xor   = '0;
    errors        = 0;
    foreach (payload_store[i]) payload_store[i] = '0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
    if (idx == REG_SYNC_VALUE) begin
      sync_value = value;
    end else if (idx == REG_FUNCTION_CODE) begin
      function_code = value;
    end
  endfunction

  function void push_word(logic [7:0] data, int idx, logic fin, logic [1:0] st);
    frame_word_t w;
    w.payload_byte = data;
    w.byte_index   = idx[5:0];
    w.last         = fin;
    w.status       = st;
    pending_words.push_back(w);
  endfunction

  function void take_byte(logic [7:0] b);
    int len;
    case (phase)
      PH_FUNC: begin
        phase = (b == function_code) ? PH_LEN : PH_HUNT;
      end
      PH_LEN: begin
        if (int'(b) > MAX_PAYLOAD_DEF) begin
          push_word(8'h00, 0, 1'b1, ST_OVERFLOW);
          phase = PH_HUNT;
        end else begin
          frame_length = b;
          bytes_taken  = '0;
          running_xor  = '0;
          phase        = (b == 8'h00) ? PH_CHECK : PH_DATA;
        end
      end
      PH_DATA: begin
        if (bytes_taken < frame_length && int'(bytes_taken) < MAX_PAYLOAD_DEF)
          payload_store[bytes_taken] = b;
        running_xor = running_xor ^ b;
        bytes_taken = bytes_taken + 7'd1;
        if ({1'b0, bytes_taken} >= frame_length) phase = PH_CHECK;
      end
      PH_CHECK: begin
        if (b != running_xor) begin
          push_word(8'h00, 0, 1'b1, ST_BADSUM);
        end else if (frame_length == 8'h00) begin
          push_word(8'h00, 0, 1'b1, ST_EMPTY);
        end else begin
          len = (int'(frame_length) > MAX_PAYLOAD_DEF) ? MAX_PAYLOAD_DEF : int'(frame_length);
          for (int i = 0; i < len; i++)
            push_word(payload_store[i], i, (i + 1 == len), ST_GOOD);
        end
        phase = PH_HUNT;
      end
      default: begin
        phase = (b == sync_value) ? PH_FUNC : PH_HUNT;
      end
    endcase
  endfunction

  function void check_word(frame_word_t got);
    frame_word_t want;
    if (pending_words.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected word: byte %02h idx %0d last %0b status %0d",
                 got.payload_byte, got.byte_index, got.last, got.status);
      return;
    end
    want = pending_words.pop_front();
    if (got.payload_byte !== want.payload_byte || got.byte_index !== want.byte_index ||
        got.last !== want.last || got.status !== want.status) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: want byte %02h idx %0d last %0b status %0d, got byte %02h idx %0d last %0b status %0d",
                 want.payload_byte, want.byte_index, want.last, want.status,
                 got.payload_byte, got.byte_index, got.last, got.status);
    end
  endfunction

  function int pending();
    return pending_words.size();
  endfunction
endclass

module tb;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 60;

  // reset registers: noise, wrong function, empty, bad empty, overflow 17 and 255,
  // good one-byte frame, bad checksum
  localparam logic [7:0] DIRECTED [31] = '{
    8'h00, 8'h7E,
    8'hFF, 8'h11,
    8'hFF, 8'h10, 8'h00, 8'h00,
    8'hFF, 8'h10, 8'h00, 8'h5A,
    8'hFF, 8'h10, 8'h11,
    8'hFF, 8'h10, 8'hFF,
    8'hFF, 8'h10, 8'h01, 8'hFF, 8'hFF,
    8'hFF, 8'h10, 8'h02, 8'h00, 8'h80, 8'h7F,
    8'h00, 8'h00
  };

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_wdata;

  slxfp_in_if  in_if ();
  slxfp_out_if out_if ();

  frame_checker chk;
  bit           steady;
  int unsigned  hold_seq;

  sync_length_xor_frame_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD_DEF)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_if),
    .out_ch    (out_if)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic send_byte(input logic [7:0] b);
    if (!steady && $urandom_range(0, 99) < 34) begin
      in_if.valid <= 1'b0;
      do @(posedge clk); while (!steady && $urandom_range(0, 99) < 34);
    end
    in_if.valid   <= 1'b1;
    in_if.rx_byte <= b;
    do @(posedge clk); while (!in_if.ready);
    chk.take_byte(b);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (chk.pending() != 0);
    // closing bytes may still be in flight without a word
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write enable drops for one cycle so back-to-back writes never share a time step
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    chk.write_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic send_random_frame(inout int unsigned items);
    int unsigned roll;
    int unsigned len;
    int unsigned cut;
    logic [7:0]  sum;
    logic [7:0]  b;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      // line noise, mostly ignored by the parser
      cut = $urandom_range(1, 3);
      repeat (cut) send_byte(8'($urandom_range(0, 255)));
      items += cut;
      return;
    end
    send_byte(chk.sync_value);
    if (roll < 14) begin
      send_byte(chk.function_code ^ 8'($urandom_range(1, 255)));
      items += 2;
      return;
    end
    send_byte(chk.function_code);
    if (roll < 20) begin
      cut = $urandom_range(0, 2);
      len = (cut == 0) ? 17 : (cut == 1) ? 255 : $urandom_range(17, 255);
      send_byte(8'(len));
      items += 3;
      return;
    end
    if (roll < 26) begin
      // frame cut short: the next frame's bytes land in this one
      len = $urandom_range(2, 8);
      cut = $urandom_range(1, len - 1);
      send_byte(8'(len));
      repeat (cut) send_byte(8'($urandom_range(0, 255)));
      items += 3 + cut;
      return;
    end
    cut = $urandom_range(0, 99);
    len = (cut < 60) ? $urandom_range(0, 3) :
          (cut < 90) ? $urandom_range(4, 15) : MAX_PAYLOAD_DEF;
    send_byte(8'(len));
    sum = 8'h00;
    for (int i = 0; i < int'(len); i++) begin
      b = 8'($urandom_range(0, 255));
      sum ^= b;
      send_byte(b);
    end
    if ($urandom_range(0, 99) < 15) sum ^= 8'($urandom_range(1, 255));
    send_byte(sum);
    items += 4 + len;
  endtask

  // result side: random ready, one long hold-off on request
  initial begin : word_sink
    int unsigned hold_left;
    int unsigned hold_seen;
    frame_word_t got;
    hold_left    = 0;
    hold_seen    = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid === 1'b1 && out_if.ready) begin
        got.payload_byte = out_if.payload_byte;
        got.byte_index   = out_if.byte_index;
        got.last         = out_if.last;
        got.status       = out_if.status;
        chk.check_word(got);
      end
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= steady || ($urandom_range(0, 99) >= 34);
      end
    end
  end

  initial begin : stimulus
    int unsigned items;
    logic [7:0]  sync_v;
    logic [7:0]  func_v;
    chk           = new();
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    in_if.valid   = 1'b0;
    in_if.rx_byte = '0;
    steady        = 1'b0;
    hold_seq      = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) send_byte(DIRECTED[i]);
    wait_drained();

    // unused indexes must leave both registers alone
    write_reg(REG_UNUSED_2, 8'($urandom_range(0, 255)));
    write_reg(REG_UNUSED_3, 8'($urandom_range(0, 255)));

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin sync_v = 8'h00; func_v = 8'h00; end
        1: begin sync_v = 8'hFF; func_v = 8'hFF; end
        4: begin sync_v = 8'hFF; func_v = 8'h10; end
        default: begin
          sync_v = 8'($urandom_range(0, 255));
          func_v = 8'($urandom_range(0, 255));
        end
      endcase
      write_reg(REG_SYNC_VALUE, sync_v);
      write_reg(REG_FUNCTION_CODE, func_v);
      steady = (p == 2);
      if (p == 3) hold_seq++;
      items = 0;
      while (items < PHASE_ITEMS) send_random_frame(items);
      wait_drained();
    end
    steady = 1'b0;

    if (chk.errors == 0 && chk.pending() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("tb: done, errors");
    $finish;
  end

endmodule
